// File: sv/rab_pkg.sv
// Package for the RGB565 alpha blender: field widths, the pixel word type
// and the helpers that widen 565 channels and swap byte order.
// It depends on nothing else.
package rab_pkg;

    localparam int PixelWidth   = 16;
    localparam int ChannelWidth = 8;

    typedef logic [PixelWidth-1:0]   pixel_t;
    typedef logic [ChannelWidth-1:0] channel_t;

    typedef struct packed {
        pixel_t   dest_pixel;
        channel_t src_alpha;
        channel_t src_red;
        channel_t src_green;
        channel_t src_blue;
        logic     last_in_run;
    } pixel_word_t;

    function automatic channel_t widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic channel_t widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic pixel_t swap_bytes(input pixel_t v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

// File: sv/rab_if.sv
// Valid/ready channel interfaces for the blender's input and result words.
// They depend on rab_pkg for the field types.
interface rab_pix_in_if;
    logic               valid;
    logic               ready;
    rab_pkg::pixel_t    dest_pixel;
    rab_pkg::channel_t  src_alpha;
    rab_pkg::channel_t  src_red;
    rab_pkg::channel_t  src_green;
    rab_pkg::channel_t  src_blue;
    logic               last_in_run;

    modport source (
        output valid, dest_pixel, src_alpha, src_red, src_green, src_blue, last_in_run,
        input  ready
    );
    modport sink (
        input  valid, dest_pixel, src_alpha, src_red, src_green, src_blue, last_in_run,
        output ready
    );
endinterface

interface rab_pix_out_if;
    logic               valid;
    logic               ready;
    rab_pkg::pixel_t    blended_pixel;
    logic               run_end;

    modport source (
        output valid, blended_pixel, run_end,
        input  ready
    );
    modport sink (
        input  valid, blended_pixel, run_end,
        output ready
    );
endinterface

// File: sv/rgb565_alpha_blend.sv
// Top level of the RGB565 alpha blender: input register, blend logic and
// result register. Depends on rab_pkg, rab_if and rab_blend_core.
//
// Each accepted word is held in the input register and moves into the result
// register when that register is free or its word is being taken, and is offered
// from there on pix_out until taken. A new word is accepted every cycle
// while results are taken; the input stalls only when both registers hold a
// word and the result is not taken. The throughput of one word per cycle is
// set by the single blend stage between those two registers. The byte order
// register resets to swapped order and should be written only while idle.
module rgb565_alpha_blend (
    input  logic                clk,
    input  logic                rst_n,
    rab_pix_in_if.sink          pix_in,
    rab_pix_out_if.source       pix_out,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic                 swap_reg;
    logic                 in_valid_reg;
    rab_pkg::pixel_word_t in_word_reg;
    logic                 out_valid_reg;
    rab_pkg::pixel_t      out_pixel_reg;
    logic                 out_last_reg;
    rab_pkg::pixel_t      blended_next;
    logic                 out_load;
    logic                 in_load;

    assign out_load     = in_valid_reg && (!out_valid_reg || pix_out.ready);
    assign in_load      = pix_in.valid && pix_in.ready;
    assign pix_in.ready = !in_valid_reg || !out_valid_reg || pix_out.ready;

    rab_blend_core u_core (
        .word    (in_word_reg),
        .swapped (swap_reg),
        .blended (blended_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg      <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                swap_reg <= cfg_wdata;
            end
            if (pix_in.ready)
            begin
                in_valid_reg <= pix_in.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_word_reg.dest_pixel  <= pix_in.dest_pixel;
            in_word_reg.src_alpha   <= pix_in.src_alpha;
            in_word_reg.src_red     <= pix_in.src_red;
            in_word_reg.src_green   <= pix_in.src_green;
            in_word_reg.src_blue    <= pix_in.src_blue;
            in_word_reg.last_in_run <= pix_in.last_in_run;
        end
        if (out_load)
        begin
            out_pixel_reg <= blended_next;
            out_last_reg  <= in_word_reg.last_in_run;
        end
    end

    assign pix_out.valid         = out_valid_reg;
    assign pix_out.blended_pixel = out_pixel_reg;
    assign pix_out.run_end       = out_last_reg;

endmodule

// File: sv/rab_channel_mix.sv
// Weighted mix of one 8-bit source channel with one 8-bit destination channel.
// It depends on rab_pkg for the channel type.
module rab_channel_mix (
    input  rab_pkg::channel_t src,
    input  rab_pkg::channel_t dst,
    input  rab_pkg::channel_t alpha,
    output rab_pkg::channel_t mixed
);

    logic [8:0]  wsrc;
    logic [8:0]  wdst;
    logic [16:0] psrc;
    logic [16:0] pdst;
    logic [16:0] total;

    // The two weights always add up to 257, so the sum stays within 16 bits.
    assign wsrc  = {1'b0, alpha} + 9'd1;
    assign wdst  = 9'd256 - {1'b0, alpha};
    assign psrc  = wsrc * {9'd0, src};
    assign pdst  = wdst * {9'd0, dst};
    assign total = psrc + pdst;
    assign mixed = total[15:8];

endmodule

// File: sv/rab_blend_core.sv
// Combinational blend of one registered word: unpacks the 565 destination,
// mixes the three channels and repacks. Depends on rab_pkg and rab_channel_mix.
module rab_blend_core (
    input  rab_pkg::pixel_word_t word,
    input  logic                 swapped,
    output rab_pkg::pixel_t      blended
);

    rab_pkg::pixel_t   native;
    rab_pkg::pixel_t   packed_pix;
    rab_pkg::channel_t dst_r;
    rab_pkg::channel_t dst_g;
    rab_pkg::channel_t dst_b;
    rab_pkg::channel_t mix_r;
    rab_pkg::channel_t mix_g;
    rab_pkg::channel_t mix_b;

    assign native = swapped ? rab_pkg::swap_bytes(word.dest_pixel) : word.dest_pixel;
    assign dst_r  = rab_pkg::widen5(native[15:11]);
    assign dst_g  = rab_pkg::widen6(native[10:5]);
    assign dst_b  = rab_pkg::widen5(native[4:0]);

    rab_channel_mix u_mix_r (
        .src   (word.src_red),
        .dst   (dst_r),
        .alpha (word.src_alpha),
        .mixed (mix_r)
    );

    rab_channel_mix u_mix_g (
        .src   (word.src_green),
        .dst   (dst_g),
        .alpha (word.src_alpha),
        .mixed (mix_g)
    );

    rab_channel_mix u_mix_b (
        .src   (word.src_blue),
        .dst   (dst_b),
        .alpha (word.src_alpha),
        .mixed (mix_b)
    );

    assign packed_pix = {mix_r[7:3], mix_g[7:2], mix_b[7:3]};
    assign blended    = swapped ? rab_pkg::swap_bytes(packed_pix) : packed_pix;

endmodule

// File: tb/rgb565_alpha_blend_tb.sv
// Testbench for rgb565_alpha_blend: a directed table and random pixel words, run
// through both byte orders with random idling on both channels.
// Depends on rab_pkg, the rab_if interfaces and the blender RTL.
module rgb565_alpha_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rab_pkg::pixel_t blended_pixel;
        logic            run_end;
    } blend_result_t;

    typedef struct packed {
        rab_pkg::pixel_t   dest;
        rab_pkg::channel_t alpha;
        rab_pkg::channel_t red;
        rab_pkg::channel_t green;
        rab_pkg::channel_t blue;
        logic              last;
        logic              typed;
        rab_pkg::pixel_t   result;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    rab_pix_in_if  pix_in ();
    rab_pix_out_if pix_out ();

    rgb565_alpha_blend u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    blend_result_t expected_blends [$];
    int            mismatch_count = 0;
    logic          order_swapped_model = 1'b1;
    logic          typed_known;
    blend_result_t typed_value;
    bit            source_idle_on = 1'b0;
    bit            sink_stalls_on = 1'b0;

    // The first rows are read off by hand for the swapped order in force after reset.
    directed_row_t directed_rows [0:15] = '{
        '{16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'hFFFF},
        '{16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000},
        '{16'h1234, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 16'h00F8},
        '{16'hABCD, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 16'hE007},
        '{16'h0000, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 16'h1F00},
        '{16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000},
        '{16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'hFFFF},
        '{16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000},
        '{16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0000},
        '{16'hF800, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 16'h0000},
        '{16'h07E0, 8'h01, 8'h7F, 8'h7F, 8'h7F, 1'b0, 1'b0, 16'h0000},
        '{16'h001F, 8'hFE, 8'h01, 8'hFE, 8'h80, 1'b0, 1'b0, 16'h0000},
        '{16'h5555, 8'h80, 8'hAA, 8'h55, 8'hFF, 1'b1, 1'b0, 16'h0000},
        '{16'hAAAA, 8'h7F, 8'h55, 8'hAA, 8'h00, 1'b0, 1'b0, 16'h0000},
        '{16'h8001, 8'hFF, 8'h07, 8'h03, 8'hF8, 1'b0, 1'b0, 16'h0000},
        '{16'h00FF, 8'h01, 8'hF0, 8'h0F, 8'h3C, 1'b1, 1'b0, 16'h0000}
    };

    always #5 clk = ~clk;

    function automatic rab_pkg::channel_t mix_channel(input rab_pkg::channel_t src,
                                                      input rab_pkg::channel_t dst,
                                                      input rab_pkg::channel_t alpha);
        int unsigned acc;
        acc = (32'd1 + alpha) * src + (32'd256 - alpha) * dst;
        return acc[15:8];
    endfunction

    function automatic blend_result_t predict_blend(input rab_pkg::pixel_word_t w,
                                                    input logic swapped);
        rab_pkg::pixel_t   native_pix;
        rab_pkg::pixel_t   packed_pix;
        logic [4:0]        r5;
        logic [5:0]        g6;
        logic [4:0]        b5;
        rab_pkg::channel_t rw;
        rab_pkg::channel_t gw;
        rab_pkg::channel_t bw;
        blend_result_t     res;
        native_pix = swapped ? {w.dest_pixel[7:0], w.dest_pixel[15:8]} : w.dest_pixel;
        r5 = native_pix[15:11];
        g6 = native_pix[10:5];
        b5 = native_pix[4:0];
        rw = (rab_pkg::channel_t'(r5) << 3) | (rab_pkg::channel_t'(r5) >> 2);
        gw = (rab_pkg::channel_t'(g6) << 2) | (rab_pkg::channel_t'(g6) >> 4);
        bw = (rab_pkg::channel_t'(b5) << 3) | (rab_pkg::channel_t'(b5) >> 2);
        rw = mix_channel(w.src_red, rw, w.src_alpha);
        gw = mix_channel(w.src_green, gw, w.src_alpha);
        bw = mix_channel(w.src_blue, bw, w.src_alpha);
        packed_pix = {rw[7:3], gw[7:2], bw[7:3]};
        res.blended_pixel = swapped ? {packed_pix[7:0], packed_pix[15:8]} : packed_pix;
        res.run_end = w.last_in_run;
        return res;
    endfunction

    always @(posedge clk)
    begin : blend_monitor
        blend_result_t        got;
        blend_result_t        want;
        rab_pkg::pixel_word_t w;
        if (rst_n !== 1'b1)
        begin
            order_swapped_model = 1'b1;
        end
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                got.blended_pixel = pix_out.blended_pixel;
                got.run_end = pix_out.run_end;
                if (expected_blends.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual %h/%b",
                             $time, got.blended_pixel, got.run_end);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_blends.pop_front();
                    if (got.blended_pixel !== want.blended_pixel)
                    begin
                        $display("%0t: blended_pixel expected %h actual %h",
                                 $time, want.blended_pixel, got.blended_pixel);
                        mismatch_count++;
                    end
                    if (got.run_end !== want.run_end)
                    begin
                        $display("%0t: run_end expected %b actual %b",
                                 $time, want.run_end, got.run_end);
                        mismatch_count++;
                    end
                end
            end
            if (pix_in.valid && pix_in.ready)
            begin
                w.dest_pixel = pix_in.dest_pixel;
                w.src_alpha = pix_in.src_alpha;
                w.src_red = pix_in.src_red;
                w.src_green = pix_in.src_green;
                w.src_blue = pix_in.src_blue;
                w.last_in_run = pix_in.last_in_run;
                if (typed_known)
                    expected_blends.push_back(typed_value);
                else
                    expected_blends.push_back(predict_blend(w, order_swapped_model));
            end
            if (cfg_we)
                order_swapped_model = cfg_wdata;
        end
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_out.ready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    task automatic drive_word(input rab_pkg::pixel_word_t w, input logic typed,
                              input blend_result_t res);
        pix_in.valid <= 1'b1;
        pix_in.dest_pixel <= w.dest_pixel;
        pix_in.src_alpha <= w.src_alpha;
        pix_in.src_red <= w.src_red;
        pix_in.src_green <= w.src_green;
        pix_in.src_blue <= w.src_blue;
        pix_in.last_in_run <= w.last_in_run;
        typed_known <= typed;
        typed_value <= res;
        do
            @(posedge clk);
        while (pix_in.ready !== 1'b1);
    endtask

    task automatic pause_source();
        if (source_idle_on && $urandom_range(0, 3) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        pix_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_blends.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_order(input logic swapped);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= swapped;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic walk_directed(input logic use_typed);
        rab_pkg::pixel_word_t w;
        blend_result_t        res;
        foreach (directed_rows[i])
        begin
            w.dest_pixel = directed_rows[i].dest;
            w.src_alpha = directed_rows[i].alpha;
            w.src_red = directed_rows[i].red;
            w.src_green = directed_rows[i].green;
            w.src_blue = directed_rows[i].blue;
            w.last_in_run = directed_rows[i].last;
            res.blended_pixel = directed_rows[i].result;
            res.run_end = directed_rows[i].last;
            drive_word(w, use_typed && directed_rows[i].typed, res);
            pause_source();
        end
    endtask

    task automatic random_words(input int count, input bit with_idling);
        rab_pkg::pixel_word_t w;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                source_idle_on = with_idling && ($urandom_range(0, 2) != 0);
                sink_stalls_on = with_idling && ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 7))
                0: w.dest_pixel = 16'h0000;
                1: w.dest_pixel = 16'hFFFF;
                default: w.dest_pixel = rab_pkg::pixel_t'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 7))
                0: w.src_alpha = 8'h00;
                1: w.src_alpha = 8'hFF;
                default: w.src_alpha = rab_pkg::channel_t'($urandom_range(0, 255));
            endcase
            w.src_red = rab_pkg::channel_t'($urandom_range(0, 255));
            w.src_green = rab_pkg::channel_t'($urandom_range(0, 255));
            w.src_blue = rab_pkg::channel_t'($urandom_range(0, 255));
            w.last_in_run = ($urandom_range(0, 3) == 0);
            drive_word(w, 1'b0, '0);
            pause_source();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        pix_in.valid <= 1'b0;
        pix_in.dest_pixel <= '0;
        pix_in.src_alpha <= '0;
        pix_in.src_red <= '0;
        pix_in.src_green <= '0;
        pix_in.src_blue <= '0;
        pix_in.last_in_run <= 1'b0;
        typed_known <= 1'b0;
        typed_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        source_idle_on = 1'b1;
        sink_stalls_on = 1'b1;
        walk_directed(1'b1);
        random_words(400, 1'b1);

        write_order(1'b0);
        source_idle_on = 1'b1;
        sink_stalls_on = 1'b1;
        walk_directed(1'b0);
        random_words(400, 1'b1);

        write_order(1'b1);
        random_words(400, 1'b1);

        write_order(1'b0);
        random_words(450, 1'b0);

        wait_for_results();
        if (expected_blends.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, expected_blends.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("%0t: run timed out", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/rab_pkg.sv
sv/rab_if.sv
sv/rab_channel_mix.sv
sv/rab_blend_core.sv
sv/rgb565_alpha_blend.sv
tb/rgb565_alpha_blend_tb.sv
